FILE: rtl/wavelet_matrix_query_unit_macros.svh
// assertion helpers for the wavelet matrix query unit checker
`ifndef WAVELET_MATRIX_QUERY_UNIT_MACROS_SVH
`define WAVELET_MATRIX_QUERY_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define WMQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wmq check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define WMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmq check failed");

`endif

FILE: rtl/wmq_pkg.sv
package wmq_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_BITS = 16;
  localparam int BLOCK_BITS = 64;
  localparam int OFS_BITS   = 6;

  localparam int ACT_W = 2;
  localparam int VAL_W = 16;
  localparam int POS_W = 11;
  localparam int K_W   = 10;
  localparam int CNT_W = 11;
  localparam int ST_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_KTH   = 2'd1,
    ACT_COUNT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

endpackage

FILE: rtl/wmq_ram.sv
module wmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/wmq_rank.sv
module wmq_rank #(
  parameter int ZW = 11
) (
  input  logic [ZW-1:0]                   prefix,
  input  logic [wmq_pkg::BLOCK_BITS-1:0]  block,
  input  logic [wmq_pkg::OFS_BITS-1:0]    ofs,
  output logic [ZW-1:0]                   zeros
);

  localparam int BB = wmq_pkg::BLOCK_BITS;
  localparam int OW = wmq_pkg::OFS_BITS;

  logic [BB-1:0] mask;
  logic [BB-1:0] hit;
  logic [OW:0]   ones;

  // zeros below the offset inside the block, added to the block prefix
  always_comb begin
    mask = (BB'(1) << ofs) - BB'(1);
    hit  = block & mask;
    ones = '0;
    for (int i = 0; i < BB; i++) begin
      ones = ones + (OW + 1)'(hit[i]);
    end
    zeros = prefix + ZW'(ofs) - ZW'(ones);
  end

endmodule

FILE: rtl/wavelet_matrix_query_unit.sv
// load: a plain load stores the item; a load with last also builds each level with a scan pass over
// the items rounded up to whole 64-bit blocks and then a split pass over the n items
// query: per value bit level, two rank lookups through one shared rank unit and the block and
// prefix memory ports; one request at a time; a result may wait in the output register
// rst_n (synchronous) clears the item count, the built flag and the handshake state;
// the value, plane and prefix memories hold no reset value and need no clearing pass
module wavelet_matrix_query_unit #(
  parameter int MAX_ITEMS  = wmq_pkg::MAX_ITEMS,
  parameter int VALUE_BITS = wmq_pkg::VALUE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [wmq_pkg::ACT_W-1:0] in_action,
  input  logic [wmq_pkg::VAL_W-1:0] in_item_value,
  input  logic                      in_last,
  input  logic [wmq_pkg::POS_W-1:0] in_left,
  input  logic [wmq_pkg::POS_W-1:0] in_right,
  input  logic [wmq_pkg::K_W-1:0]   in_rank_k,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [wmq_pkg::VAL_W-1:0] out_answer,
  output logic [wmq_pkg::CNT_W-1:0] out_count,
  output logic [wmq_pkg::ST_W-1:0]  out_status
);

  localparam int BB    = wmq_pkg::BLOCK_BITS;
  localparam int OW    = wmq_pkg::OFS_BITS;
  localparam int VAL_W = wmq_pkg::VAL_W;
  localparam int CNT_W = wmq_pkg::CNT_W;
  localparam int POS_W = wmq_pkg::POS_W;
  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int PW    = $clog2(MAX_ITEMS + 1);
  localparam int NBLK  = (MAX_ITEMS + BB - 1) / BB;
  localparam int QW    = $clog2(NBLK + 1);
  localparam int ZW    = $clog2(NBLK * BB + 1);
  localparam int LW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int BAW   = LW + QW;
  localparam int CW    = (PW > POS_W) ? PW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SPLIT = 5'b00100,
    S_QUERY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    BUF_L = 2'd0,
    BUF_X = 2'd1,
    BUF_Y = 2'd2
  } buf_t;

  state_t state_r, state_nxt;
  logic              built_r;
  logic [PW-1:0]     n_r;
  logic              out_valid_r;
  logic              rv_r;

  logic [LW-1:0]     lv_r;
  logic [ZW-1:0]     cnt_r;
  logic [ZW-1:0]     ridx_r;
  logic [BB-1:0]     word_r;
  logic [ZW-1:0]     zacc_r;
  logic [PW-1:0]     ztot_r;
  logic [PW-1:0]     zpos_r;
  logic [PW-1:0]     opos_r;
  buf_t              src_r;
  buf_t              dst_r;
  logic [PW-1:0]     zt_r [VALUE_BITS];
  logic [PW-1:0]     lo_r, hi_r, k_r, zlo_r, zhi_r;
  logic [VALUE_BITS-1:0] x_r;
  logic [VALUE_BITS-1:0] val_r;
  logic              qkth_r;
  logic [1:0]        step_r;
  logic [VAL_W-1:0]  res_answer_r;
  logic [CNT_W-1:0]  res_count_r;
  wmq_pkg::status_t  res_status_r;
  logic [VAL_W-1:0]  out_answer_r;
  logic [CNT_W-1:0]  out_count_r;
  wmq_pkg::status_t  out_status_r;

  logic acc, out_free, full, kth_ok, val_ok;
  logic [CW-1:0] c_left, c_right, c_n, c_k;
  logic [ZW:0]   lim_w;
  logic [ZW-1:0] lim1;
  logic iss1, iss2, proc1, proc2, scan_done, split_done;
  logic [VALUE_BITS-1:0] l_rdata, x_rdata, y_rdata, src_data;
  logic bit1, bit2;
  logic [ZW-1:0] zacc_new;
  logic [BB-1:0] word_new;
  logic blk_end;
  logic bwe, pwe;
  logic [BAW-1:0] bwaddr, pwaddr, braddr;
  logic [ZW-1:0] pwdata;
  logic [BB-1:0] b_rdata;
  logic [ZW-1:0] p_rdata;
  logic [PW-1:0] qpos;
  logic [OW-1:0] rofs;
  logic [ZW-1:0] rank_z;
  logic [PW-1:0] split_addr;
  logic [PW-1:0] c0, lo_one, hi_one, lo_nx, hi_nx, k_nx;
  logic go_one;
  logic [VALUE_BITS-1:0] x_nx;
  logic [PW-1:0] right_clamp;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign full     = (n_r == PW'(MAX_ITEMS));

  assign c_left  = CW'(in_left);
  assign c_right = CW'(in_right);
  assign c_n     = CW'(n_r);
  assign c_k     = CW'(in_rank_k);
  assign kth_ok  = built_r && (c_left < c_right) && (c_right <= c_n)
                   && (c_k < (c_right - c_left));
  assign val_ok  = ((32'(in_item_value) >> VALUE_BITS) == 32'd0);
  assign right_clamp = (c_right > c_n) ? n_r : PW'(in_right);

  // build passes
  assign lim_w = (((ZW + 1)'(n_r) + (ZW + 1)'(BB - 1)) >> OW) << OW;
  assign lim1  = ZW'(lim_w);
  assign iss1  = (state_r == S_SCAN) && (cnt_r < lim1);
  assign iss2  = (state_r == S_SPLIT) && (cnt_r < ZW'(n_r));
  assign proc1 = rv_r && (state_r == S_SCAN);
  assign proc2 = rv_r && (state_r == S_SPLIT);
  assign scan_done  = (state_r == S_SCAN) && !iss1 && !rv_r;
  assign split_done = (state_r == S_SPLIT) && !iss2 && !rv_r;

  always_comb begin
    case (src_r)
      BUF_L:   src_data = l_rdata;
      BUF_X:   src_data = x_rdata;
      default: src_data = y_rdata;
    endcase
  end

  assign bit1     = (ridx_r < ZW'(n_r)) ? src_data[lv_r] : 1'b0;
  assign bit2     = src_data[lv_r];
  assign zacc_new = zacc_r + ZW'(!bit1);
  assign word_new = {bit1, word_r[BB-1:1]};
  assign blk_end  = (ridx_r[OW-1:0] == {OW{1'b1}});

  assign bwe    = proc1 && blk_end;
  assign bwaddr = {lv_r, QW'(ridx_r >> OW)};
  assign pwe    = (proc1 && blk_end) || ((state_r == S_SCAN) && (cnt_r == '0) && !rv_r);
  assign pwaddr = (proc1 && blk_end) ? {lv_r, QW'(ridx_r >> OW) + QW'(1)} : {lv_r, QW'(0)};
  assign pwdata = (proc1 && blk_end) ? zacc_new : '0;
  assign split_addr = bit2 ? opos_r : zpos_r;

  // query walk
  assign qpos   = (step_r == 2'd0) ? lo_r : hi_r;
  assign braddr = {lv_r, QW'(qpos >> OW)};
  assign rofs   = (step_r == 2'd1) ? lo_r[OW-1:0] : hi_r[OW-1:0];

  assign c0     = zhi_r - zlo_r;
  assign go_one = qkth_r ? !(k_r < c0) : val_r[lv_r];
  assign lo_one = zt_r[lv_r] + (lo_r - zlo_r);
  assign hi_one = zt_r[lv_r] + (hi_r - zhi_r);
  assign lo_nx  = go_one ? lo_one : zlo_r;
  assign hi_nx  = go_one ? hi_one : zhi_r;
  assign k_nx   = (go_one && qkth_r) ? (k_r - c0) : k_r;
  assign x_nx   = (x_r << 1) | VALUE_BITS'(go_one);

  wmq_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_load_ram (
    .clk   (clk),
    .we    (acc && (in_action == wmq_pkg::ACT_LOAD) && !full),
    .waddr (n_r[IW-1:0]),
    .wdata (VALUE_BITS'(in_item_value)),
    .raddr (cnt_r[IW-1:0]),
    .rdata (l_rdata)
  );

  wmq_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_x_ram (
    .clk   (clk),
    .we    (proc2 && (dst_r == BUF_X)),
    .waddr (split_addr[IW-1:0]),
    .wdata (src_data),
    .raddr (cnt_r[IW-1:0]),
    .rdata (x_rdata)
  );

  wmq_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_y_ram (
    .clk   (clk),
    .we    (proc2 && (dst_r == BUF_Y)),
    .waddr (split_addr[IW-1:0]),
    .wdata (src_data),
    .raddr (cnt_r[IW-1:0]),
    .rdata (y_rdata)
  );

  wmq_ram #(.WIDTH(BB), .DEPTH(1 << BAW)) u_block_ram (
    .clk   (clk),
    .we    (bwe),
    .waddr (bwaddr),
    .wdata (word_new),
    .raddr (braddr),
    .rdata (b_rdata)
  );

  wmq_ram #(.WIDTH(ZW), .DEPTH(1 << BAW)) u_prefix_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwaddr),
    .wdata (pwdata),
    .raddr (braddr),
    .rdata (p_rdata)
  );

  wmq_rank #(.ZW(ZW)) u_rank (
    .prefix (p_rdata),
    .block  (b_rdata),
    .ofs    (rofs),
    .zeros  (rank_z)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_action)
            wmq_pkg::ACT_LOAD:  state_nxt = in_last ? S_SCAN : S_DONE;
            wmq_pkg::ACT_KTH:   state_nxt = kth_ok ? S_QUERY : S_DONE;
            wmq_pkg::ACT_COUNT: state_nxt = (built_r && val_ok) ? S_QUERY : S_DONE;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (split_done) state_nxt = (lv_r == '0) ? S_DONE : S_SCAN;
      end
      S_QUERY: begin
        if ((step_r == 2'd3) && (lv_r == '0)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= iss1 || iss2;
      if (acc && (in_action == wmq_pkg::ACT_LOAD)) begin
        built_r <= 1'b0;
        if (!full) n_r <= n_r + PW'(1);
      end else if (split_done && (lv_r == '0)) begin
        built_r <= 1'b1;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= cnt_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          res_answer_r <= '0;
          res_count_r  <= '0;
          res_status_r <= wmq_pkg::ST_OK;
          lv_r         <= LW'(VALUE_BITS - 1);
          step_r       <= 2'd0;
          x_r          <= '0;
          case (in_action)
            wmq_pkg::ACT_LOAD: begin
              if (full) res_status_r <= wmq_pkg::ST_FULL;
              src_r  <= BUF_L;
              dst_r  <= BUF_X;
              cnt_r  <= '0;
              zacc_r <= '0;
              ztot_r <= '0;
            end
            wmq_pkg::ACT_KTH: begin
              if (!kth_ok) res_status_r <= wmq_pkg::ST_BAD;
              lo_r   <= PW'(in_left);
              hi_r   <= PW'(in_right);
              k_r    <= PW'(in_rank_k);
              qkth_r <= 1'b1;
            end
            wmq_pkg::ACT_COUNT: begin
              if (!built_r) res_status_r <= wmq_pkg::ST_BAD;
              lo_r   <= '0;
              hi_r   <= right_clamp;
              k_r    <= '0;
              val_r  <= VALUE_BITS'(in_item_value);
              qkth_r <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (iss1) cnt_r <= cnt_r + ZW'(1);
        if (proc1) begin
          word_r <= word_new;
          zacc_r <= zacc_new;
          if ((ridx_r < ZW'(n_r)) && !bit1) ztot_r <= ztot_r + PW'(1);
        end
        if (scan_done) begin
          zt_r[lv_r] <= ztot_r;
          zpos_r     <= '0;
          opos_r     <= ztot_r;
          cnt_r      <= '0;
        end
      end
      S_SPLIT: begin
        if (iss2) cnt_r <= cnt_r + ZW'(1);
        if (proc2) begin
          if (bit2) opos_r <= opos_r + PW'(1);
          else      zpos_r <= zpos_r + PW'(1);
        end
        if (split_done && (lv_r != '0)) begin
          lv_r   <= lv_r - LW'(1);
          src_r  <= dst_r;
          dst_r  <= (dst_r == BUF_X) ? BUF_Y : BUF_X;
          cnt_r  <= '0;
          zacc_r <= '0;
          ztot_r <= '0;
        end
      end
      S_QUERY: begin
        case (step_r)
          2'd0: step_r <= 2'd1;
          2'd1: begin
            zlo_r  <= PW'(rank_z);
            step_r <= 2'd2;
          end
          2'd2: begin
            zhi_r  <= PW'(rank_z);
            step_r <= 2'd3;
          end
          default: begin
            lo_r   <= lo_nx;
            hi_r   <= hi_nx;
            k_r    <= k_nx;
            x_r    <= x_nx;
            step_r <= 2'd0;
            if (lv_r == '0) begin
              res_answer_r <= qkth_r ? VAL_W'(x_nx) : '0;
              res_count_r  <= qkth_r ? '0 : CNT_W'(hi_nx - lo_nx);
            end else begin
              lv_r <= lv_r - LW'(1);
            end
          end
        endcase
      end
      default: ;
    endcase
    if ((state_r == S_DONE) && out_free) begin
      out_answer_r <= res_answer_r;
      out_count_r  <= res_count_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

FILE: rtl/wmq_checker.sv
`include "wavelet_matrix_query_unit_macros.svh"

module wmq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [wmq_pkg::VAL_W-1:0] out_answer,
  input logic [wmq_pkg::CNT_W-1:0] out_count,
  input logic [wmq_pkg::ST_W-1:0]  out_status
);

  `WMQ_ASSERT_NOW(a_status_code, out_valid, out_status != 2'd3)
  `WMQ_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `WMQ_ASSERT_NOW(a_error_zero, out_valid && (out_status != wmq_pkg::ST_OK), (out_answer == '0) && (out_count == '0))
  `WMQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_answer) && $stable(out_count) && $stable(out_status))

endmodule

bind wavelet_matrix_query_unit wmq_checker u_wmq_checker (.*);
